// ----- rtl/bld_pkg.sv -----
// ---------------------------------------------------------------------------
// bld_pkg
// Shared types and codes for the bounded list deque: word formats,
// command and status codes, and the per-cell control word.
// ---------------------------------------------------------------------------
`default_nettype none

package bld_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int CMD_W     = 3;
  localparam int STAT_W    = 2;
  localparam int FILL_W    = 5;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic signed [DATA_W-1:0] item_value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic [STAT_W-1:0]        status;
    logic [FILL_W-1:0]        fill_level;
  } out_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_REMOVE
  } cell_op_t;

  // broadcast to every cell in the chain
  typedef struct packed {
    cell_op_t                 op;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/bld_cell.sv -----
// ---------------------------------------------------------------------------
// bld_cell
// One list position: holds an entry, compares it with the broadcast value,
// and loads from its left or right neighbor when the list shifts.
// ---------------------------------------------------------------------------
`default_nettype none

module bld_cell #(
  parameter int DEPTH = bld_pkg::DEPTH_DEF,
  parameter int INDEX = 0
) (
  input  wire                               clk,
  input  wire bld_pkg::cell_ctrl_t          ctrl,
  input  wire [$clog2(DEPTH+1)-1:0]         count,
  input  wire logic signed [bld_pkg::DATA_W-1:0] left_data,
  input  wire logic signed [bld_pkg::DATA_W-1:0] right_data,
  input  wire                               match_in,
  output logic                              match_out,
  output logic signed [bld_pkg::DATA_W-1:0] data_out,
  output logic signed [bld_pkg::DATA_W-1:0] tail_out
);

  localparam int CNT_W = $clog2(DEPTH+1);
  localparam logic [CNT_W-1:0] MY_POS = CNT_W'(INDEX);

  logic signed [bld_pkg::DATA_W-1:0] data_r;
  logic signed [bld_pkg::DATA_W-1:0] data_nxt;
  logic                              occupied;
  logic                              at_count;
  logic                              is_tail;
  logic                              hit;

  assign occupied  = MY_POS < count;
  assign at_count  = MY_POS == count;
  assign is_tail   = (MY_POS + CNT_W'(1)) == count;
  // first-match chain: once any cell at or ahead of here matched, close the gap
  assign hit       = match_in | (occupied && (data_r == ctrl.value));
  assign match_out = hit;
  assign data_out  = data_r;
  assign tail_out  = is_tail ? data_r : '0;

  always_comb begin
    data_nxt = data_r;
    unique case (ctrl.op)
      bld_pkg::OP_PUSH_FRONT: data_nxt = left_data;
      bld_pkg::OP_PUSH_BACK: begin
        if (at_count) data_nxt = ctrl.value;
      end
      bld_pkg::OP_POP_FRONT:  data_nxt = right_data;
      bld_pkg::OP_REMOVE: begin
        if (hit) data_nxt = right_data;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/bounded_list_deque_with_remove_unit.sv -----
// ---------------------------------------------------------------------------
// bounded_list_deque_with_remove_unit
// Ordered list of signed 32-bit words held in a chain of cells, with push
// and pop at both ends and removal of the first matching word.
// ---------------------------------------------------------------------------
//
//   channel | ports                         | word
//   --------+-------------------------------+-----------------------------
//   input   | in_valid / in_ready / in_data | command, item_value
//   result  | out_valid/out_ready/out_data  | popped_value, status, fill
//
// One command per cycle unless a held result stalls the input: the cells
// compare and shift in the cycle the word is accepted, and the result lands
// in the output register at that edge. The match chain ripples through all
// DEPTH cells and sets the cycle time. A held result blocks input only while
// out_ready is low. rst_n empties the list; cell contents are not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module bounded_list_deque_with_remove_unit #(
  parameter int DEPTH = bld_pkg::DEPTH_DEF
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  output logic            in_ready,
  input  wire bld_pkg::in_t in_data,
  output logic            out_valid,
  input  wire             out_ready,
  output bld_pkg::out_t   out_data
);

  localparam int CNT_W = $clog2(DEPTH+1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      out_valid_r;
  bld_pkg::out_t             out_data_r, out_data_nxt;
  logic                      acc;
  bld_pkg::cell_ctrl_t       ctrl;
  bld_pkg::cell_op_t         op;
  logic signed [bld_pkg::DATA_W-1:0] cell_data [DEPTH];
  logic signed [bld_pkg::DATA_W-1:0] cell_tail [DEPTH];
  logic signed [bld_pkg::DATA_W-1:0] tail_val;
  logic [DEPTH:0]            match;
  logic                      empty, full;

  assign acc       = in_valid && in_ready;
  assign in_ready  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign empty     = cnt_r == '0;
  assign full      = cnt_r == FULL_CNT;
  assign match[0]  = 1'b0;

  assign ctrl.op    = acc ? op : bld_pkg::OP_HOLD;
  assign ctrl.value = in_data.item_value;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      bld_cell #(
        .DEPTH (DEPTH),
        .INDEX (g)
      ) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .count      (cnt_r),
        .left_data  ((g == 0) ? in_data.item_value : cell_data[(g == 0) ? 0 : g-1]),
        .right_data (cell_data[(g == DEPTH-1) ? g : g+1]),
        .match_in   (match[g]),
        .match_out  (match[g+1]),
        .data_out   (cell_data[g]),
        .tail_out   (cell_tail[g])
      );
    end
  endgenerate

  // only the last occupied cell drives a nonzero tail word
  always_comb begin
    tail_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_val = tail_val | cell_tail[i];
    end
  end

  always_comb begin
    op                        = bld_pkg::OP_HOLD;
    cnt_nxt                   = cnt_r;
    out_data_nxt.popped_value = '0;
    out_data_nxt.status       = bld_pkg::ST_OK;
    unique case (in_data.command)
      bld_pkg::CMD_PUSH_FRONT: begin
        if (full) begin
          out_data_nxt.status = bld_pkg::ST_FULL;
        end else begin
          op      = bld_pkg::OP_PUSH_FRONT;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      bld_pkg::CMD_PUSH_BACK: begin
        if (full) begin
          out_data_nxt.status = bld_pkg::ST_FULL;
        end else begin
          op      = bld_pkg::OP_PUSH_BACK;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      bld_pkg::CMD_POP_FRONT: begin
        if (empty) begin
          out_data_nxt.status = bld_pkg::ST_EMPTY;
        end else begin
          op                        = bld_pkg::OP_POP_FRONT;
          out_data_nxt.popped_value = cell_data[0];
          cnt_nxt                   = cnt_r - CNT_W'(1);
        end
      end
      bld_pkg::CMD_POP_BACK: begin
        if (empty) begin
          out_data_nxt.status = bld_pkg::ST_EMPTY;
        end else begin
          out_data_nxt.popped_value = tail_val;
          cnt_nxt                   = cnt_r - CNT_W'(1);
        end
      end
      bld_pkg::CMD_REMOVE: begin
        op = bld_pkg::OP_REMOVE;
        if (match[DEPTH]) begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end else begin
          out_data_nxt.status = bld_pkg::ST_NOTFOUND;
        end
      end
      default: op = bld_pkg::OP_HOLD;
    endcase
    out_data_nxt.fill_level = bld_pkg::FILL_W'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) out_data_r <= out_data_nxt;
  end

  // ---- assertions ----
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("entry count above depth");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid)
    else $error("accepted word produced no result");

  a_full_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == bld_pkg::ST_FULL
      |-> out_data.fill_level == bld_pkg::FILL_W'(DEPTH))
    else $error("full status with list not full");

  a_empty_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == bld_pkg::ST_EMPTY
      |-> out_data.fill_level == '0 && out_data.popped_value == '0)
    else $error("empty status with nonzero level or value");

endmodule

`default_nettype wire
